// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the stencil neighbour RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ===== hw/rtl/gsni_pkg.sv =====
// Types, constants and helper functions for the stencil neighbour index block.
// No dependencies.
package gsni_pkg;

    localparam int SZW        = 11;  // size register / coordinate width
    localparam int IDXW       = 30;  // input cell index width
    localparam int NIW        = 31;  // neighbour index width
    localparam int DIV_STEP   = 5;   // quotient bits per divider stage
    localparam int DIV_STAGES = 6;   // IDXW / DIV_STEP
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam int OCCW       = 5;

    typedef enum logic [2:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_WRAP_X = 3'd3,
        CFG_WRAP_Y = 3'd4,
        CFG_WRAP_Z = 3'd5,
        CFG_MODE   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [SZW-1:0] sx;
        logic [SZW-1:0] sy;
        logic [SZW-1:0] sz;
        logic           wrap_x;
        logic           wrap_y;
        logic           wrap_z;
    } cfg_t;

    typedef struct packed {
        logic [SZW-1:0] x;
        logic [SZW-1:0] y;
        logic [SZW-1:0] z;
        logic           bad;
    } cell_t;

    typedef struct packed {
        cell_t             site;
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
        logic              last;
    } req_t;

    typedef struct packed {
        logic [IDXW-1:0] num;
        logic [SZW-1:0]  rem;
        logic [IDXW-1:0] quo;
    } div_t;

    // DIV_STEP restoring division steps; rem stays below d.
    function automatic div_t div_steps(div_t a, logic [SZW-1:0] d);
        div_t     r;
        logic [SZW:0] t;
        r = a;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            t     = {r.rem, r.num[IDXW-1]};
            r.num = {r.num[IDXW-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t     = t - {1'b0, d};
                r.quo = {r.quo[IDXW-2:0], 1'b1};
            end
            else
            begin
                r.quo = {r.quo[IDXW-2:0], 1'b0};
            end
            r.rem = t[SZW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/gsni_decode.sv =====
// Pipelined split of a linear cell index into x, y, z plus range check.
// Depends on gsni_pkg.
module gsni_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [gsni_pkg::IDXW-1:0]   in_index,
    input  gsni_pkg::cfg_t              cfg,
    output logic                        out_valid,
    output gsni_pkg::cell_t             out_cell
);

    localparam int NST = 2 * gsni_pkg::DIV_STAGES;

    typedef struct packed {
        logic [gsni_pkg::IDXW-1:0] idx;
        gsni_pkg::div_t            dv;
        logic [gsni_pkg::SZW-1:0]  x;
        logic [32:0]               p;
        logic                      bad;
    } stg_t;

    logic [NST:0] v_reg;
    stg_t         pl_reg  [0:NST];
    stg_t         pl_next [1:NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NST-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        pl_reg[0].idx    <= in_index;
        pl_reg[0].dv.num <= in_index;
        pl_reg[0].dv.rem <= '0;
        pl_reg[0].dv.quo <= '0;
        pl_reg[0].x      <= '0;
        pl_reg[0].p      <= '0;
        pl_reg[0].bad    <= 1'b0;
        for (int s = 1; s <= NST; s++)
            pl_reg[s] <= pl_next[s];
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        always_comb
        begin
            stg_t                     t;
            logic [gsni_pkg::SZW-1:0] d;
            logic [21:0]              p1;
            t  = pl_reg[s];
            p1 = cfg.sx * cfg.sy;
            // second division starts on the quotient of the first
            if (s == gsni_pkg::DIV_STAGES)
            begin
                t.x      = t.dv.rem;
                t.dv.num = t.dv.quo;
                t.dv.rem = '0;
                t.dv.quo = '0;
            end
            d    = (s < gsni_pkg::DIV_STAGES) ? cfg.sx : cfg.sy;
            t.dv = gsni_pkg::div_steps(t.dv, d);
            if (s == 0)
                t.p = {11'b0, p1};
            if (s == 1)
                t.p = {11'b0, t.p[21:0]} * {22'b0, cfg.sz};
            if (s == 2)
                t.bad = ({3'b0, t.idx} >= t.p);
            pl_next[s+1] = t;
        end
    end

    assign out_valid    = v_reg[NST];
    assign out_cell.x   = pl_reg[NST].x;
    assign out_cell.y   = pl_reg[NST].dv.rem;
    assign out_cell.z   = pl_reg[NST].dv.quo[gsni_pkg::SZW-1:0];
    assign out_cell.bad = pl_reg[NST].bad;

endmodule

// ===== hw/rtl/gsni_emit.sv =====
// Three-stage neighbour index generator: step coordinates, then two multiplies.
// Depends on gsni_pkg.
module gsni_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  gsni_pkg::req_t         req,
    input  gsni_pkg::cfg_t         cfg,
    output logic                   done,
    output logic signed [30:0]     neighbour_index,
    output logic signed [1:0]      offset_x,
    output logic signed [1:0]      offset_y,
    output logic signed [1:0]      offset_z,
    output logic                   bad_index,
    output logic                   last
);

    localparam int W = gsni_pkg::SZW;

    // {ok, coordinate}
    function automatic logic [W:0] step_axis(logic [W-1:0] c, logic signed [1:0] d,
                                            logic [W-1:0] n, logic wrap);
        logic [W:0] r;
        r = {1'b1, c};
        if (d == -2'sd1)
        begin
            if (c == '0)
                r = {wrap, n - W'(1)};
            else
                r = {1'b1, c - W'(1)};
        end
        else if (d == 2'sd1)
        begin
            if ({1'b0, c} + (W+1)'(1) >= {1'b0, n})
                r = {wrap, {W{1'b0}}};
            else
                r = {1'b1, c + W'(1)};
        end
        return r;
    endfunction

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
        logic              bad;
        logic              last;
        logic              ok;
    } tag_t;

    logic [W:0]   sx_w, sy_w, sz_w;
    logic [2:0]   v_reg;
    tag_t         a_tag_reg, b_tag_reg;
    logic [W-1:0] a_nx_reg, a_ny_reg, a_nz_reg, b_nx_reg;
    logic [22:0]  b_t_reg;
    logic [33:0]  c_full;

    assign sx_w = step_axis(req.site.x, req.dx, cfg.sx, cfg.wrap_x);
    assign sy_w = step_axis(req.site.y, req.dy, cfg.sy, cfg.wrap_y);
    assign sz_w = step_axis(req.site.z, req.dz, cfg.sz, cfg.wrap_z);
    assign c_full = {23'b0, b_nx_reg} + {11'b0, b_t_reg} * {23'b0, cfg.sx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], req_valid};
    end

    always_ff @(posedge clk)
    begin
        a_tag_reg <= '{dx: req.dx, dy: req.dy, dz: req.dz, bad: req.site.bad,
                       last: req.last, ok: sx_w[W] & sy_w[W] & sz_w[W]};
        a_nx_reg  <= sx_w[W-1:0];
        a_ny_reg  <= sy_w[W-1:0];
        a_nz_reg  <= sz_w[W-1:0];
        b_tag_reg <= a_tag_reg;
        b_nx_reg  <= a_nx_reg;
        b_t_reg   <= {12'b0, a_ny_reg} + {1'b0, {11'b0, cfg.sy} * {11'b0, a_nz_reg}};
        if (!b_tag_reg.ok || b_tag_reg.bad)
            neighbour_index <= '1;
        else
            neighbour_index <= c_full[30:0];
        offset_x  <= b_tag_reg.dx;
        offset_y  <= b_tag_reg.dy;
        offset_z  <= b_tag_reg.dz;
        bad_index <= b_tag_reg.bad;
        last      <= b_tag_reg.last;
    end

    assign done = v_reg[2];

endmodule

// ===== hw/rtl/grid_stencil_neighbour_index.sv =====
// Top level of the stencil neighbour index generator.
// Depends on gsni_pkg, gsni_decode, gsni_emit and assert_macros.svh.
//
// Each request (start high while busy is low) carries one linear cell index.
// The block answers with 6 results in seven-point mode, 27 in 27-point mode,
// or a single flagged result when the index lies outside the grid; last marks
// the final result of a request. Results leave one per clock on done and the
// receiver cannot stall them, so the output port sets the rate. Requests may
// be issued in every cycle while busy stays low; a 16-entry queue behind the
// decode pipeline absorbs bursts, and busy rises when queued plus in-flight
// requests fill it. The first result reaches the ports through 18 register
// stages: 13 for the pipelined coordinate divider (an input register and two
// dividers of six stages, five quotient bits each), one for the queue, one for
// the sequencer, three for the neighbour multiply pipeline.
// Configure only while idle. Sizes of zero act as one; sizes above AXIS_MAX
// saturate.
`include "assert_macros.svh"

module grid_stencil_neighbour_index #(
    parameter int AXIS_MAX = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [29:0]                 cell_index,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [10:0]                 cfg_data,
    output logic                        done,
    output logic signed [30:0]          neighbour_index,
    output logic signed [1:0]           offset_x,
    output logic signed [1:0]           offset_y,
    output logic signed [1:0]           offset_z,
    output logic                        bad_index,
    output logic                        last
);

    localparam int W = gsni_pkg::SZW;
    localparam logic [W-1:0] AXIS_CAP = (AXIS_MAX > 2047) ? 11'd2047 : W'(AXIS_MAX);

    // ---------------- configuration registers ----------------
    logic [W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic         wrap_x_reg, wrap_y_reg, wrap_z_reg, mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= W'(1);
            size_y_reg <= W'(1);
            size_z_reg <= W'(1);
            wrap_x_reg <= 1'b0;
            wrap_y_reg <= 1'b0;
            wrap_z_reg <= 1'b0;
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (gsni_pkg::cfg_reg_t'(cfg_index))
                gsni_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                gsni_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                gsni_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                gsni_pkg::CFG_WRAP_X: wrap_x_reg <= cfg_data[0];
                gsni_pkg::CFG_WRAP_Y: wrap_y_reg <= cfg_data[0];
                gsni_pkg::CFG_WRAP_Z: wrap_z_reg <= cfg_data[0];
                gsni_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [W-1:0] clamp(logic [W-1:0] v);
        logic [W-1:0] s;
        s = (v == '0) ? W'(1) : v;
        if (s > AXIS_CAP)
            s = AXIS_CAP;
        return s;
    endfunction

    gsni_pkg::cfg_t cfg;
    assign cfg.sx     = clamp(size_x_reg);
    assign cfg.sy     = clamp(size_y_reg);
    assign cfg.sz     = clamp(size_z_reg);
    assign cfg.wrap_x = wrap_x_reg;
    assign cfg.wrap_y = wrap_y_reg;
    assign cfg.wrap_z = wrap_z_reg;

    // ---------------- request accept and decode ----------------
    logic            accept;
    logic            dec_v;
    gsni_pkg::cell_t dec_cell;

    assign accept = start & ~busy;

    gsni_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_index (cell_index),
        .cfg      (cfg),
        .out_valid(dec_v),
        .out_cell (dec_cell)
    );

    // ---------------- queue of decoded cells ----------------
    // occ_reg counts requests accepted and not yet taken by the sequencer,
    // so decode output can never find the queue full.
    gsni_pkg::cell_t                 fifo_mem [gsni_pkg::FIFO_DEPTH];
    logic [gsni_pkg::FIFO_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [gsni_pkg::OCCW-1:0]       fifo_cnt_reg, occ_reg;
    logic                            pop;
    logic                            fifo_ne;

    assign fifo_ne = (fifo_cnt_reg != '0);
    assign busy    = (occ_reg == gsni_pkg::OCCW'(gsni_pkg::FIFO_DEPTH));

    always_ff @(posedge clk)
    begin
        if (dec_v)
            fifo_mem[wr_ptr_reg] <= dec_cell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            if (dec_v)
                wr_ptr_reg <= wr_ptr_reg + gsni_pkg::FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + gsni_pkg::FIFO_AW'(1);
            fifo_cnt_reg <= fifo_cnt_reg + gsni_pkg::OCCW'(dec_v) - gsni_pkg::OCCW'(pop);
            occ_reg      <= occ_reg + gsni_pkg::OCCW'(accept) - gsni_pkg::OCCW'(pop);
        end
    end

    // ---------------- neighbour sequencer ----------------
    // Face order: left, right, lower, upper, below, above.
    // Full order: z +1..-1, y +1..-1, x -1..+1.
    gsni_pkg::cell_t cur_reg;
    logic            cur_v_reg;
    logic [2:0]      k_reg;
    logic [1:0]      ix_reg, iy_reg, iz_reg;
    gsni_pkg::req_t  req;

    always_comb
    begin
        req.site = cur_reg;
        req.dx   = 2'sd0;
        req.dy   = 2'sd0;
        req.dz   = 2'sd0;
        req.last = 1'b0;
        if (cur_reg.bad)
        begin
            req.last = 1'b1;
        end
        else if (!mode_reg)
        begin
            case (k_reg)
                3'd0:    req.dx = -2'sd1;
                3'd1:    req.dx = 2'sd1;
                3'd2:    req.dy = -2'sd1;
                3'd3:    req.dy = 2'sd1;
                3'd4:    req.dz = -2'sd1;
                default: req.dz = 2'sd1;
            endcase
            req.last = (k_reg == 3'd5);
        end
        else
        begin
            req.dx   = (ix_reg == 2'd0) ? -2'sd1 : ((ix_reg == 2'd1) ? 2'sd0 : 2'sd1);
            req.dy   = (iy_reg == 2'd0) ? 2'sd1 : ((iy_reg == 2'd1) ? 2'sd0 : -2'sd1);
            req.dz   = (iz_reg == 2'd0) ? 2'sd1 : ((iz_reg == 2'd1) ? 2'sd0 : -2'sd1);
            req.last = (ix_reg == 2'd2) && (iy_reg == 2'd2) && (iz_reg == 2'd2);
        end
    end

    assign pop = fifo_ne & (~cur_v_reg | req.last);

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= fifo_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            k_reg     <= '0;
            ix_reg    <= '0;
            iy_reg    <= '0;
            iz_reg    <= '0;
        end
        else if (!cur_v_reg || req.last)
        begin
            cur_v_reg <= pop;
            k_reg     <= '0;
            ix_reg    <= '0;
            iy_reg    <= '0;
            iz_reg    <= '0;
        end
        else
        begin
            k_reg <= k_reg + 3'd1;
            if (ix_reg == 2'd2)
            begin
                ix_reg <= '0;
                if (iy_reg == 2'd2)
                begin
                    iy_reg <= '0;
                    iz_reg <= iz_reg + 2'd1;
                end
                else
                begin
                    iy_reg <= iy_reg + 2'd1;
                end
            end
            else
            begin
                ix_reg <= ix_reg + 2'd1;
            end
        end
    end

    // ---------------- neighbour index pipeline ----------------
    gsni_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (cur_v_reg),
        .req            (req),
        .cfg            (cfg),
        .done           (done),
        .neighbour_index(neighbour_index),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .offset_z       (offset_z),
        .bad_index      (bad_index),
        .last           (last)
    );

    // ---------------- assertions ----------------
    `CHK_ALWAYS(a_occ_bound, occ_reg <= gsni_pkg::OCCW'(gsni_pkg::FIFO_DEPTH), "occupancy overrun")
    `CHK_ALWAYS(a_cnt_le_occ, fifo_cnt_reg <= occ_reg, "queue count exceeds occupancy")
    `CHK_IMPLY(a_no_overflow, dec_v, fifo_cnt_reg != gsni_pkg::OCCW'(gsni_pkg::FIFO_DEPTH), "queue overflow")
    `CHK_IMPLY(a_bad_result, done && bad_index, last && (neighbour_index == '1), "bad request result malformed")

endmodule

// ===== dv/grid_stencil_neighbour_index_tb.sv =====
// Self-checking testbench for the stencil neighbour index generator.
// Depends on gsni_pkg and the grid_stencil_neighbour_index RTL only.
module grid_stencil_neighbour_index_tb;

    typedef struct {
        logic signed [30:0] nidx;
        logic signed [1:0]  ox;
        logic signed [1:0]  oy;
        logic signed [1:0]  oz;
        logic               bad;
        logic               lst;
    } nbr_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [29:0]        cell_index;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [10:0]        cfg_data;
    logic               done;
    logic signed [30:0] neighbour_index;
    logic signed [1:0]  offset_x;
    logic signed [1:0]  offset_y;
    logic signed [1:0]  offset_z;
    logic               bad_index;
    logic               last;

    grid_stencil_neighbour_index u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cell_index      (cell_index),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .neighbour_index (neighbour_index),
        .offset_x        (offset_x),
        .offset_y        (offset_y),
        .offset_z        (offset_z),
        .bad_index       (bad_index),
        .last            (last)
    );

    // Shadow of the register file, raw as written
    logic [10:0] grid_sx, grid_sy, grid_sz;
    logic        per_x, per_y, per_z, full_mode;

    logic [29:0] pending_cells[$];
    nbr_t        expected_nbrs[$];
    int          mismatches;
    int          sender_idle_pct;
    longint      cycle_count;
    bit          cfg_pending;
    logic [2:0]  cfg_idx_q;
    logic [10:0] cfg_val_q;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint axis_cells(logic [10:0] v);
        if (v == 0)
            return 1;
        if (v > 1024)
            return 1024;
        return longint'(v);
    endfunction

    // Step one coordinate; returns -1 when it leaves a bounded axis.
    function automatic longint step_coord(longint c, int d, longint n, logic per);
        if (d < 0)
            return (c == 0) ? (per ? n - 1 : -1) : c - 1;
        if (d > 0)
            return (c + 1 >= n) ? (per ? 0 : -1) : c + 1;
        return c;
    endfunction

    function automatic nbr_t make_nbr(longint x, longint y, longint z, longint sx,
                                      longint sy, longint sz, int dx, int dy, int dz,
                                      bit lst);
        nbr_t   r;
        longint nx, ny, nz;
        nx = step_coord(x, dx, sx, per_x);
        ny = step_coord(y, dy, sy, per_y);
        nz = step_coord(z, dz, sz, per_z);
        if (nx < 0 || ny < 0 || nz < 0)
            r.nidx = -31'sd1;
        else
            r.nidx = 31'(nx + sx * (ny + sy * nz));
        r.ox  = 2'(dx);
        r.oy  = 2'(dy);
        r.oz  = 2'(dz);
        r.bad = 1'b0;
        r.lst = lst;
        return r;
    endfunction

    // Push the neighbour list that one request is expected to produce
    task automatic predict_neighbours(logic [29:0] idx);
        longint sx, sy, sz, x, y, z, rest;
        nbr_t   r;
        int     k;
        sx = axis_cells(grid_sx);
        sy = axis_cells(grid_sy);
        sz = axis_cells(grid_sz);
        if (longint'(idx) >= sx * sy * sz)
        begin
            r.nidx = -31'sd1;
            r.ox = 2'sd0; r.oy = 2'sd0; r.oz = 2'sd0;
            r.bad = 1'b1;
            r.lst = 1'b1;
            expected_nbrs.push_back(r);
            return;
        end
        x = idx % sx;
        rest = idx / sx;
        y = rest % sy;
        z = rest / sy;
        if (!full_mode)
        begin
            // face order: left, right, lower, upper, below, above
            expected_nbrs.push_back(make_nbr(x, y, z, sx, sy, sz, -1, 0, 0, 1'b0));
            expected_nbrs.push_back(make_nbr(x, y, z, sx, sy, sz, 1, 0, 0, 1'b0));
            expected_nbrs.push_back(make_nbr(x, y, z, sx, sy, sz, 0, -1, 0, 1'b0));
            expected_nbrs.push_back(make_nbr(x, y, z, sx, sy, sz, 0, 1, 0, 1'b0));
            expected_nbrs.push_back(make_nbr(x, y, z, sx, sy, sz, 0, 0, -1, 1'b0));
            expected_nbrs.push_back(make_nbr(x, y, z, sx, sy, sz, 0, 0, 1, 1'b1));
        end
        else
        begin
            k = 0;
            for (int dz = 1; dz >= -1; dz--)
                for (int dy = 1; dy >= -1; dy--)
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        expected_nbrs.push_back(
                            make_nbr(x, y, z, sx, sy, sz, dx, dy, dz, k == 26));
                        k++;
                    end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("MISMATCH @%0d %s: got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // Driver: one request per handshake, random idle per phase. The predictor
    // runs at acceptance so it sees the config in force for that request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cell_index <= '0;
            cfg_we     <= 1'b0;
            cfg_index  <= '0;
            cfg_data   <= '0;
        end
        else
        begin
            if (start && !busy)
                predict_neighbours(cell_index);
            cfg_we <= cfg_pending;
            if (cfg_pending)
            begin
                cfg_index   <= cfg_idx_q;
                cfg_data    <= cfg_val_q;
                cfg_pending = 1'b0;
            end
            if (!start || !busy)
            begin
                if (pending_cells.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start      <= 1'b1;
                    cell_index <= pending_cells.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done cycle must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (done)
            begin
                if (expected_nbrs.size() == 0)
                    report_mismatch("unexpected result, index", longint'(neighbour_index),
                                    longint'(0));
                else
                begin
                    nbr_t e;
                    e = expected_nbrs.pop_front();
                    if (neighbour_index !== e.nidx)
                        report_mismatch("neighbour_index", longint'(neighbour_index),
                                        longint'(e.nidx));
                    if (offset_x !== e.ox)
                        report_mismatch("offset_x", longint'(offset_x), longint'(e.ox));
                    if (offset_y !== e.oy)
                        report_mismatch("offset_y", longint'(offset_y), longint'(e.oy));
                    if (offset_z !== e.oz)
                        report_mismatch("offset_z", longint'(offset_z), longint'(e.oz));
                    if (bad_index !== e.bad)
                        report_mismatch("bad_index", longint'(bad_index), longint'(e.bad));
                    if (last !== e.lst)
                        report_mismatch("last", longint'(last), longint'(e.lst));
                end
            end
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Queue a config write; the driver puts it on the port at the next edge.
    task automatic write_reg(gsni_pkg::cfg_reg_t r, logic [10:0] v);
        cfg_idx_q   = r;
        cfg_val_q   = v;
        cfg_pending = 1'b1;
        @(posedge clk);
        @(posedge clk);
        case (r)
            gsni_pkg::CFG_SIZE_X: grid_sx = v;
            gsni_pkg::CFG_SIZE_Y: grid_sy = v;
            gsni_pkg::CFG_SIZE_Z: grid_sz = v;
            gsni_pkg::CFG_WRAP_X: per_x = v[0];
            gsni_pkg::CFG_WRAP_Y: per_y = v[0];
            gsni_pkg::CFG_WRAP_Z: per_z = v[0];
            gsni_pkg::CFG_MODE:   full_mode = v[0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [10:0] sx, logic [10:0] sy, logic [10:0] sz,
                            logic wx, logic wy, logic wz, logic m);
        write_reg(gsni_pkg::CFG_SIZE_X, sx);
        write_reg(gsni_pkg::CFG_SIZE_Y, sy);
        write_reg(gsni_pkg::CFG_SIZE_Z, sz);
        write_reg(gsni_pkg::CFG_WRAP_X, {10'b0, wx});
        write_reg(gsni_pkg::CFG_WRAP_Y, {10'b0, wy});
        write_reg(gsni_pkg::CFG_WRAP_Z, {10'b0, wz});
        write_reg(gsni_pkg::CFG_MODE, {10'b0, m});
    endtask

    // Wait until the block has drained, then a margin for bad-free idle.
    task automatic drain();
        while (pending_cells.size() > 0 || start || expected_nbrs.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic longint cell_count();
        return axis_cells(grid_sx) * axis_cells(grid_sy) * axis_cells(grid_sz);
    endfunction

    // Random cells: mostly inside the grid, some just past, some anywhere.
    task automatic queue_random(int n);
        longint cnt;
        cnt = cell_count();
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:       pending_cells.push_back(30'($urandom()));
                1:       pending_cells.push_back(30'(cnt + $urandom_range(3)));
                2:       pending_cells.push_back(30'(cnt - 1));
                3:       pending_cells.push_back(30'd0);
                default: pending_cells.push_back(30'({$urandom(), $urandom()} % cnt));
            endcase
        end
    endtask

    initial
    begin
        logic [10:0] sizes[3];
        mismatches      = 0;
        cycle_count     = 0;
        cfg_pending     = 1'b0;
        sender_idle_pct = 0;
        grid_sx = 11'd1; grid_sy = 11'd1; grid_sz = 11'd1;
        per_x = 1'b0; per_y = 1'b0; per_z = 1'b0; full_mode = 1'b0;
        start      = 1'b0;
        cfg_we     = 1'b0;
        cell_index = '0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, a single-cell grid with and without wrap
        pending_cells.push_back(30'd0);
        pending_cells.push_back(30'd1);
        pending_cells.push_back(30'h3FFF_FFFF);
        drain();
        set_grid(11'd0, 11'd1, 11'd1, 1'b1, 1'b1, 1'b1, 1'b1);
        pending_cells.push_back(30'd0);
        pending_cells.push_back(30'd1);
        drain();
        // Oversized sizes saturate; corners of a full 1024^3 grid
        set_grid(11'h7FF, 11'd1025, 11'd1024, 1'b0, 1'b0, 1'b0, 1'b0);
        pending_cells.push_back(30'd0);
        pending_cells.push_back(30'd1023);
        pending_cells.push_back(30'h3FFF_FFFF);
        pending_cells.push_back(30'h2AAA_AAAA);
        pending_cells.push_back(30'h1555_5555);
        drain();
        set_grid(11'd1024, 11'd1024, 11'd1024, 1'b1, 1'b1, 1'b1, 1'b1);
        pending_cells.push_back(30'd0);
        pending_cells.push_back(30'h3FFF_FFFF);
        pending_cells.push_back(30'd1024 * 30'd1023);
        drain();
        set_grid(11'd3, 11'd3, 11'd3, 1'b0, 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < 27; i += 3)
            pending_cells.push_back(30'(i + i / 9));
        pending_cells.push_back(30'd27);
        drain();

        // Random phases: varied configs, sender idle pressure per phase
        for (int ph = 0; ph < 16; ph++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                case ($urandom_range(5))
                    0:       sizes[a] = 11'($urandom_range(2047));
                    1:       sizes[a] = 11'($urandom_range(1, 2));
                    2:       sizes[a] = 11'd1024;
                    default: sizes[a] = 11'($urandom_range(1, 12));
                endcase
            end
            set_grid(sizes[0], sizes[1], sizes[2], 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
            case (ph % 3)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 78;
                default: sender_idle_pct = 16;
            endcase
            queue_random(25);
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
